/* rtl/core/sdesbm_pkg.sv */
`timescale 1ns / 1ps

package sdesbm_pkg;

  // fixed widths
  localparam int unsigned BlockW  = 12;
  localparam int unsigned HalfW   = 6;
  localparam int unsigned KeyW    = 9;
  localparam int unsigned RkeyW   = 8;
  localparam int unsigned RoundsW = 5;
  localparam int unsigned MaxRounds = 16;

  // register indexes
  localparam logic [1:0] REG_KEY    = 2'd0;
  localparam logic [1:0] REG_ROUNDS = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_DEC    = 2'd3;

  // chaining modes, code three behaves as ecb
  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CTR = 2'd2;

  // microprogram step addresses
  localparam logic [1:0] STEP_IDLE  = 2'd0;
  localparam logic [1:0] STEP_LOAD  = 2'd1;
  localparam logic [1:0] STEP_ROUND = 2'd2;
  localparam logic [1:0] STEP_FIN   = 2'd3;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       round;
    logic       fin;
    cond_e      cond;
    logic [1:0] target;
  } ucode_t;

  // s-boxes indexed by the 4-bit nibble: msb picks the row
  localparam logic [2:0] SBOX_A [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };
  localparam logic [2:0] SBOX_B [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  function automatic ucode_t ucode_rom(input logic [1:0] pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_LOAD: begin
        w.load   = 1'b1;
        w.cond   = COND_NEVER;
        w.target = STEP_IDLE;
      end
      STEP_ROUND: begin
        w.round  = 1'b1;
        w.cond   = COND_MORE;
        w.target = STEP_ROUND;
      end
      STEP_FIN: begin
        w.fin    = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_FIN;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [RkeyW-1:0] expand6(input logic [HalfW-1:0] r);
    return {r[5], r[4], r[2], r[3], r[2], r[3], r[1], r[0]};
  endfunction

  // rotate left within nine bits, amount 0..8
  function automatic logic [KeyW-1:0] rotl9(input logic [KeyW-1:0] k,
                                            input logic [3:0] amt);
    logic [2*KeyW-1:0] d;
    d = {k, k} << amt;
    return d[2*KeyW-1:KeyW];
  endfunction

  function automatic logic [BlockW-1:0] swap_halves(input logic [BlockW-1:0] v);
    return {v[HalfW-1:0], v[BlockW-1:HalfW]};
  endfunction

endpackage

/* rtl/core/simplified_des_block_modes_unit.sv */
`timescale 1ns / 1ps

// channel   | dir | handshake               | payload
// s_axis    | in  | s_axis_tvalid/tready    | tdata: data_block, init_value; tuser: start
// m_axis    | out | m_axis_tvalid/tready    | tdata: result_block
// cfg       | in  | cfg_valid/ready         | cfg_index, cfg_wdata
//
// one block at a time through a single shared round unit, n rounds per block,
// n = round count saturated at 16
// a taken request runs the load, round and final steps before the result is registered
// rst_ni clears config to defaults, chain to zero and parks the microprogram
// a stalled output holds the sequencer in its final step; cfg is always ready

module simplified_des_block_modes_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [11:0] data_block, [23:12] init_value
  input  logic        s_axis_tuser_i,   // [0] start_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [11:0] result_block, [15:12] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_wdata_i
);
  import sdesbm_pkg::*;

  // configuration registers
  logic [KeyW-1:0]    key_q;
  logic [RoundsW-1:0] rounds_q;
  logic [1:0]         mode_q;
  logic               dec_q;

  // datapath
  logic [BlockW-1:0]  data_q, chain_q, v_q, v_round;
  logic [RoundsW-1:0] k_q;
  logic [BlockW-1:0]  out_q;
  logic               out_valid_q;

  // sequencer
  logic [1:0] pc_q, pc_d;
  ucode_t     uw;
  logic       take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      rounds_q <= RoundsW'(1);
      mode_q   <= MODE_ECB;
      dec_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KEY:    key_q    <= cfg_wdata_i;
        REG_ROUNDS: rounds_q <= cfg_wdata_i[RoundsW-1:0];
        REG_MODE:   mode_q   <= cfg_wdata_i[1:0];
        REG_DEC:    dec_q    <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  // mode decode
  logic is_cbc, is_ctr, use_dec;
  logic [RoundsW-1:0] n_rounds;
  assign is_cbc   = (mode_q == MODE_CBC);
  assign is_ctr   = (mode_q == MODE_CTR);
  assign use_dec  = dec_q && !is_ctr;
  assign n_rounds = (rounds_q > RoundsW'(MaxRounds)) ? RoundsW'(MaxRounds) : rounds_q;

  // current control word
  assign uw   = ucode_rom(pc_q);
  assign take = uw.accept && s_axis_tvalid_i;
  assign s_axis_tready_o = uw.accept;

  logic more, out_busy, fin_go;
  assign more     = (k_q != n_rounds);
  assign out_busy = out_valid_q && !m_axis_tready_i;
  assign fin_go   = uw.fin && !out_busy;

  always_comb begin
    logic jump;
    unique case (uw.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_INPUT: jump = !s_axis_tvalid_i;
      COND_MORE:     jump = more;
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : pc_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pc_q <= STEP_IDLE;
    else         pc_q <= pc_d;
  end

  // round key: encrypt walks up, decrypt walks down from n-1
  logic [RoundsW-1:0] idx_full;
  logic [3:0]         idx, rot;
  logic [KeyW-1:0]    key_rot;
  assign idx_full = use_dec ? (n_rounds - RoundsW'(1) - k_q) : k_q;
  assign idx      = idx_full[3:0];
  assign rot      = (idx >= 4'd9) ? idx - 4'd9 : idx;
  assign key_rot  = rotl9(key_q, rot);

  sdesbm_round u_round (
    .v_i    (v_q),
    .rkey_i (key_rot[KeyW-1:1]),
    .v_o    (v_round)
  );

  // block source and final combine
  logic [BlockW-1:0] src, core_out, res;
  assign src = is_ctr            ? chain_q :
               (is_cbc && !dec_q) ? (data_q ^ chain_q) : data_q;
  assign core_out = use_dec ? swap_halves(v_q) : v_q;
  assign res = (is_cbc && dec_q) ? (core_out ^ chain_q) :
               is_ctr            ? (core_out ^ data_q) : core_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (take && s_axis_tuser_i) begin
      chain_q <= s_axis_tdata_i[23:12];
    end else if (fin_go) begin
      if (is_cbc)      chain_q <= dec_q ? data_q : res;
      else if (is_ctr) chain_q <= chain_q + BlockW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) data_q <= s_axis_tdata_i[11:0];
    if (uw.load) begin
      v_q <= use_dec ? swap_halves(src) : src;
      k_q <= '0;
    end else if (uw.round && more) begin
      v_q <= v_round;
      k_q <= k_q + RoundsW'(1);
    end
    if (fin_go) out_q <= res;
  end

  // output register, frees the sequencer once the result is parked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                         out_valid_q <= 1'b0;
    else if (fin_go)                     out_valid_q <= 1'b1;
    else if (m_axis_tready_i)            out_valid_q <= 1'b0;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_q};

endmodule

/* rtl/core/sdesbm_round.sv */
`timescale 1ns / 1ps

module sdesbm_round (
  input  logic [sdesbm_pkg::BlockW-1:0] v_i,
  input  logic [sdesbm_pkg::RkeyW-1:0]  rkey_i,
  output logic [sdesbm_pkg::BlockW-1:0] v_o
);
  import sdesbm_pkg::*;

  logic [HalfW-1:0] left, right, f;
  logic [RkeyW-1:0] x;

  assign left  = v_i[BlockW-1:HalfW];
  assign right = v_i[HalfW-1:0];
  assign x     = expand6(right) ^ rkey_i;
  assign f     = {SBOX_A[x[7:4]], SBOX_B[x[3:0]]};
  assign v_o   = {right, f ^ left};

endmodule

/* rtl/core/sdesbm_checker.sv */
`timescale 1ns / 1ps

module sdesbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one block in flight: no new request right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while block in flight");

  // a result never appears the cycle after its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result too early");

endmodule

bind simplified_des_block_modes_unit sdesbm_checker u_chk (.*);
